// ===== hw/rtl/sawlc_pkg.sv =====
// Shared types and constants for the set-associative write-back cache.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sawlc_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int LINE_W     = $clog2(MAX_BLOCKS);
  localparam int ADDR_W     = 13;
  localparam int TAG_W      = 13;
  localparam int STAMP_W    = 32;
  localparam int LOG_W      = 3;

  typedef enum logic [2:0] {
    CFG_WORDS_PER_BLOCK = 3'd0,
    CFG_BLOCK_COUNT     = 3'd1,
    CFG_WAY_COUNT       = 3'd2,
    CFG_HIT_COST        = 3'd3,
    CFG_MISS_COST       = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [5:0] words_per_block;
    logic [6:0] block_count;
    logic [6:0] way_count;
    logic [7:0] hit_cost;
    logic [9:0] miss_cost;
  } cfg_t;

  typedef struct packed {
    logic              store;
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] base;
    logic [LOG_W-1:0]  way_log;
  } req_t;

  // Position of the highest set bit; zero maps to zero.
  function automatic logic [LOG_W-1:0] msb_log(input logic [6:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < 7; i++) begin
      if (v[i]) r = LOG_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/set_assoc_writeback_lru_cache.sv =====
// Set-associative write-back, write-allocate cache model with LRU replacement; one result per
// request. The back end takes one request at a time and visits the ways of its set in turn, as
// tags and stamps sit in memories with registered reads, so each way gets a read state and then
// a compare state. Results are registered, and a stalled output holds the back end.
// Results report hit, dirty write-back and the running cycle total; line data is not kept since
// no result uses it.
module set_assoc_writeback_lru_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [12:0] address,
  input  logic [31:0] store_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        wrote_back,
  output logic [31:0] elapsed_cycles
);

  sawlc_pkg::cfg_t cfg;
  sawlc_pkg::req_t push_req, head;
  logic            push, pop, q_full, q_valid;
  logic [31:0]     unused_value;

  // The stored word only changes line data, which no result reports.
  assign unused_value = store_value;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.words_per_block <= 6'd4;
      cfg.block_count     <= 7'd16;
      cfg.way_count       <= 7'd2;
      cfg.hit_cost        <= 8'd1;
      cfg.miss_cost       <= 10'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sawlc_pkg::CFG_WORDS_PER_BLOCK: cfg.words_per_block <= cfg_data[5:0];
        sawlc_pkg::CFG_BLOCK_COUNT:     cfg.block_count     <= cfg_data[6:0];
        sawlc_pkg::CFG_WAY_COUNT:       cfg.way_count       <= cfg_data[6:0];
        sawlc_pkg::CFG_HIT_COST:        cfg.hit_cost        <= cfg_data[7:0];
        sawlc_pkg::CFG_MISS_COST:       cfg.miss_cost       <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // The front decodes the address against the geometry and queues the request.
  sawlc_front u_front (
    .in_valid(in_valid), .kind(kind), .address(address), .cfg(cfg),
    .q_full(q_full), .in_stall(in_stall), .push(push), .push_req(push_req)
  );

  sawlc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_req(push_req), .pop(pop),
    .full(q_full), .q_valid(q_valid), .head(head)
  );

  // The back end scans the set and commits the result into the output register.
  sawlc_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .head(head), .pop(pop),
    .out_stall(out_stall), .out_valid(out_valid), .hit(hit), .wrote_back(wrote_back),
    .elapsed_cycles(elapsed_cycles)
  );

`ifndef SYNTH
  // A hit never evicts, so it never writes back.
  assert property (@(posedge clk) disable iff (rst) out_valid && hit |-> !wrote_back)
    else $error("write-back reported on a hit");
  // The front only stalls when the queue holds requests.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> q_valid)
    else $error("front stalled with an empty queue");
`endif

endmodule

// ===== hw/rtl/sawlc_front.sv =====
// Front end: takes an access request and reduces it to tag, set base and way count.
// Depends on sawlc_pkg.
module sawlc_front (
  input  logic                       in_valid,
  input  logic                       kind,
  input  logic [12:0]                address,
  input  sawlc_pkg::cfg_t            cfg,
  input  logic                       q_full,
  output logic                       in_stall,
  output logic                       push,
  output sawlc_pkg::req_t            push_req
);

  logic [2:0]  lwpb, lblk, lway0, lw, ibits;
  logic [3:0]  obits;
  logic [12:0] set_full, set_mask;

  always_comb begin
    lwpb  = (cfg.words_per_block >= 6'd32) ? 3'd5
          : sawlc_pkg::msb_log({1'b0, cfg.words_per_block});
    lblk  = (cfg.block_count >= 7'd64) ? 3'd6 : sawlc_pkg::msb_log(cfg.block_count);
    lway0 = (cfg.way_count >= 7'd64) ? 3'd6 : sawlc_pkg::msb_log(cfg.way_count);
    lw    = (lway0 < lblk) ? lway0 : lblk;
    ibits = lblk - lw;
    obits = {1'b0, lwpb} + 4'd2;
    set_mask = (13'd1 << ibits) - 13'd1;
    set_full = (address >> obits) & set_mask;
    push_req.store   = kind;
    push_req.tag     = address >> (obits + {1'b0, ibits});
    push_req.base    = sawlc_pkg::LINE_W'(set_full << lw);
    push_req.way_log = lw;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

// ===== hw/rtl/sawlc_queue.sv =====
// Two-entry request queue between the front end and the back end.
// Depends on sawlc_pkg.
module sawlc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sawlc_pkg::req_t push_req,
  input  logic            pop,
  output logic            full,
  output logic            q_valid,
  output sawlc_pkg::req_t head
);

  sawlc_pkg::req_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_req;
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

endmodule

// ===== hw/rtl/sawlc_back.sv =====
// Back end: scans the ways of a set, picks hit, free or LRU line, updates metadata.
// Depends on sawlc_pkg.
module sawlc_back (
  input  logic            clk,
  input  logic            rst,
  input  sawlc_pkg::cfg_t cfg,
  input  logic            q_valid,
  input  sawlc_pkg::req_t head,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic            hit,
  output logic            wrote_back,
  output logic [31:0]     elapsed_cycles
);

  localparam int LW = sawlc_pkg::LINE_W;

  sawlc_pkg::back_state_t st, st_next;
  sawlc_pkg::req_t        req;

  logic [sawlc_pkg::TAG_W-1:0]   tag_mem   [sawlc_pkg::MAX_BLOCKS];
  logic [sawlc_pkg::STAMP_W-1:0] stamp_mem [sawlc_pkg::MAX_BLOCKS];
  logic [sawlc_pkg::TAG_W-1:0]   tag_q;
  logic [sawlc_pkg::STAMP_W-1:0] stamp_q;
  logic [sawlc_pkg::MAX_BLOCKS-1:0] valid_bits, dirty_bits;

  logic [6:0]    idx;
  logic [6:0]    ways;
  logic [LW-1:0] rd_addr, cur;
  logic          hit_f, inv_f;
  logic [LW-1:0] hit_idx, inv_idx, old_idx, line;
  logic [31:0]   old_val, total;
  logic          do_cmp, commit, last, wb;

  assign ways    = 7'd1 << req.way_log;
  assign rd_addr = req.base + idx[LW-1:0];
  assign cur     = rd_addr;
  assign last    = (idx + 7'd1) == ways;
  assign line    = hit_f ? hit_idx : (inv_f ? inv_idx : old_idx);
  assign wb      = !hit_f && !inv_f && dirty_bits[old_idx];

  always_comb begin
    st_next = st;
    unique case (st)
      sawlc_pkg::B_IDLE: if (q_valid) st_next = sawlc_pkg::B_READ;
      sawlc_pkg::B_READ: st_next = sawlc_pkg::B_CMP;
      sawlc_pkg::B_CMP:  st_next = last ? sawlc_pkg::B_DONE : sawlc_pkg::B_READ;
      sawlc_pkg::B_DONE: if (!out_valid || !out_stall) st_next = sawlc_pkg::B_IDLE;
      default: st_next = sawlc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop    = (st == sawlc_pkg::B_IDLE) && q_valid;
    do_cmp = (st == sawlc_pkg::B_CMP);
    commit = (st == sawlc_pkg::B_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= sawlc_pkg::B_IDLE;
      valid_bits <= '0;
      dirty_bits <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (commit) begin
        if (!hit_f) begin
          valid_bits[line] <= 1'b1;
          dirty_bits[line] <= req.store;
        end else if (req.store) begin
          dirty_bits[line] <= 1'b1;
        end
        total <= total + (hit_f ? {24'd0, cfg.hit_cost} : {22'd0, cfg.miss_cost});
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_q   <= tag_mem[rd_addr];
    stamp_q <= stamp_mem[rd_addr];
    if (commit) begin
      if (!hit_f) tag_mem[line] <= req.tag;
      stamp_mem[line] <= total;
      hit            <= hit_f;
      wrote_back     <= wb;
      elapsed_cycles <= total + (hit_f ? {24'd0, cfg.hit_cost} : {22'd0, cfg.miss_cost});
    end
    if (pop) begin
      req     <= head;
      idx     <= '0;
      hit_f   <= 1'b0;
      inv_f   <= 1'b0;
      old_val <= total;
      old_idx <= head.base;
    end else if (do_cmp) begin
      idx <= idx + 7'd1;
      if (valid_bits[cur] && tag_q == req.tag && !hit_f) begin
        hit_f   <= 1'b1;
        hit_idx <= cur;
      end
      if (!valid_bits[cur] && !inv_f) begin
        inv_f   <= 1'b1;
        inv_idx <= cur;
      end
      if (stamp_q < old_val) begin
        old_val <= stamp_q;
        old_idx <= cur;
      end
    end
  end

endmodule

// ===== verif/set_assoc_writeback_lru_cache_test.sv =====
// Self-checking testbench for the set-associative write-back LRU cache.
// Drives loads and stores, predicts hit, write-back and elapsed cycles; needs sawlc_pkg.
`timescale 1ns / 1ps

module set_assoc_writeback_lru_cache_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 95;

  typedef struct {
    logic        hit;
    logic        wrote_back;
    logic [31:0] elapsed;
  } access_result_t;

  typedef struct {
    logic        kind;
    logic [12:0] addr;
    logic [31:0] value;
    bit          typed;
    logic        hit;
    logic        wrote_back;
    logic [31:0] elapsed;
  } access_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [12:0] address;
  logic [31:0] store_value;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic        wrote_back;
  logic [31:0] elapsed_cycles;

  set_assoc_writeback_lru_cache dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .address(address),
    .store_value(store_value), .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .wrote_back(wrote_back), .elapsed_cycles(elapsed_cycles)
  );

  // Shadow copy of the cache tag state and the configuration registers.
  int unsigned   words_reg, blocks_reg, ways_reg, hit_cost_reg, miss_cost_reg;
  bit            line_valid [sawlc_pkg::MAX_BLOCKS];
  bit            line_dirty [sawlc_pkg::MAX_BLOCKS];
  logic [12:0]   line_tag   [sawlc_pkg::MAX_BLOCKS];
  logic [31:0]   line_stamp [sawlc_pkg::MAX_BLOCKS];
  logic [31:0]   cycle_total;

  access_result_t pending_results[$];
  int  errors;
  int  cycles;
  int  idle_pct;
  int  stall_pct;
  bit  hold_request;
  int  hold_left;

  // Directed accesses. The geometry is 16-byte lines, 4 sets of 2 ways, so addresses
  // 64 bytes apart share a set. The first rows are easy to work out by hand.
  access_row_t directed [14] = '{
    '{1'b0, 13'd0,    32'h0,        1'b1, 1'b0, 1'b0, 32'd100},
    '{1'b0, 13'd0,    32'h0,        1'b1, 1'b1, 1'b0, 32'd101},
    '{1'b1, 13'd4,    32'hffffffff, 1'b1, 1'b1, 1'b0, 32'd102},
    '{1'b1, 13'd64,   32'h00000000, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 13'd128,  32'h0,        1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 13'd192,  32'h0,        1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 13'd0,    32'h0,        1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 13'd8191, 32'h0,        1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b1, 13'd8190, 32'h12345678, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 13'd8188, 32'h0,        1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b1, 13'd13,   32'ha5a5a5a5, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 13'd16,   32'h0,        1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b1, 13'h1ff0, 32'h5a5a5a5a, 1'b0, 1'b0, 1'b0, 32'd0},
    '{1'b0, 13'd1,    32'h0,        1'b0, 1'b0, 1'b0, 32'd0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sizes are clamped to their range and rounded down to a power of two.
  function automatic int unsigned floor_pow2(int unsigned v, int unsigned ceiling);
    int unsigned p;
    p = 1;
    if (v > ceiling) v = ceiling;
    while (p * 2 <= v) p = p * 2;
    return p;
  endfunction

  // Applies one load or store to the shadow state and returns what the cache reports.
  function automatic access_result_t cache_access(logic is_store, logic [12:0] addr);
    access_result_t r;
    int unsigned wpb, blocks, ways, sets, line_bytes, set_idx, base, line;
    logic [12:0] tag;
    logic [31:0] oldest;
    bit found;
    wpb = floor_pow2(words_reg, 32);
    blocks = floor_pow2(blocks_reg, sawlc_pkg::MAX_BLOCKS);
    ways = floor_pow2(ways_reg, blocks);
    sets = blocks / ways;
    line_bytes = wpb * 4;
    set_idx = (addr / line_bytes) % sets;
    tag = 13'(addr / (line_bytes * sets));
    base = set_idx * ways;
    line = base;
    found = 1'b0;
    r.hit = 1'b0;
    r.wrote_back = 1'b0;
    for (int i = 0; i < ways; i++) begin
      if (!found && line_valid[base + i] && line_tag[base + i] == tag) begin
        line = base + i;
        found = 1'b1;
        r.hit = 1'b1;
      end
    end
    for (int i = 0; i < ways; i++) begin
      if (!found && !line_valid[base + i]) begin
        line = base + i;
        found = 1'b1;
      end
    end
    if (!found) begin
      // A way only counts as older when its stamp is strictly below the running total.
      oldest = cycle_total;
      for (int i = 0; i < ways; i++) begin
        if (line_stamp[base + i] < oldest) begin
          oldest = line_stamp[base + i];
          line = base + i;
        end
      end
      r.wrote_back = line_dirty[line];
    end
    if (!r.hit) begin
      line_valid[line] = 1'b1;
      line_tag[line] = tag;
      line_dirty[line] = 1'b0;
    end
    if (is_store) line_dirty[line] = 1'b1;
    line_stamp[line] = cycle_total;
    cycle_total = cycle_total + (r.hit ? hit_cost_reg : miss_cost_reg);
    r.elapsed = cycle_total;
    return r;
  endfunction

  task automatic write_reg(sawlc_pkg::cfg_reg_t idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 10'(value);
    @(posedge clk);
    unique case (idx)
      sawlc_pkg::CFG_WORDS_PER_BLOCK: words_reg = value & 6'h3f;
      sawlc_pkg::CFG_BLOCK_COUNT:     blocks_reg = value & 7'h7f;
      sawlc_pkg::CFG_WAY_COUNT:       ways_reg = value & 7'h7f;
      sawlc_pkg::CFG_HIT_COST:        hit_cost_reg = value & 8'hff;
      sawlc_pkg::CFG_MISS_COST:       miss_cost_reg = value & 10'h3ff;
      default: ;
    endcase
  endtask

  // Offers one request, waits for it to be taken, then maybe leaves the channel idle.
  // A typed expectation replaces the prediction when the row carries one.
  task automatic send_request(logic k, logic [12:0] a, logic [31:0] v,
                              bit typed, access_result_t typed_result);
    access_result_t predicted;
    in_valid <= 1'b1;
    kind <= k;
    address <= a;
    store_value <= v;
    do @(posedge clk); while (in_stall);
    predicted = cache_access(k, a);
    pending_results.push_back(typed ? typed_result : predicted);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drops valid and waits until every predicted result has come out.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_requests(int count);
    access_result_t unused;
    logic [12:0] a;
    unused = '{1'b0, 1'b0, 32'd0};
    for (int n = 0; n < count; n++) begin
      // Mostly a small window so lines get reused and evicted; the rest spans all memory.
      if ($urandom_range(99) < 75) a = 13'($urandom_range(511));
      else a = 13'($urandom_range(8191));
      send_request(1'($urandom_range(1)), a, $urandom, 1'b0, unused);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compares each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: hit=%0b wb=%0b elapsed=%0d",
                                   hit, wrote_back, elapsed_cycles);
      end else begin
        access_result_t want;
        want = pending_results.pop_front();
        if (hit !== want.hit || wrote_back !== want.wrote_back ||
            elapsed_cycles !== want.elapsed) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected hit=%0b wb=%0b elapsed=%0d, got %0b %0b %0d",
                     want.hit, want.wrote_back, want.elapsed,
                     hit, wrote_back, elapsed_cycles);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("set_assoc_writeback_lru_cache test failed");
      $finish;
    end
  end

  initial begin
    access_result_t row_result;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    hold_left = 0;
    words_reg = 4;
    blocks_reg = 16;
    ways_reg = 2;
    hit_cost_reg = 1;
    miss_cost_reg = 100;
    cycle_total = '0;
    for (int i = 0; i < sawlc_pkg::MAX_BLOCKS; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_tag[i] = '0;
      line_stamp[i] = '0;
    end
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= sawlc_pkg::CFG_WORDS_PER_BLOCK;
    cfg_data <= '0;
    in_valid <= 1'b0;
    kind <= 1'b0;
    address <= '0;
    store_value <= '0;
    out_stall <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The geometry may only change while no line is valid, so the size extremes are
    // written before any traffic and the final values settle the layout for the run.
    write_reg(sawlc_pkg::CFG_WORDS_PER_BLOCK, 0);
    write_reg(sawlc_pkg::CFG_WORDS_PER_BLOCK, 63);
    write_reg(sawlc_pkg::CFG_BLOCK_COUNT, 0);
    write_reg(sawlc_pkg::CFG_BLOCK_COUNT, 127);
    write_reg(sawlc_pkg::CFG_WAY_COUNT, 127);
    write_reg(sawlc_pkg::CFG_WORDS_PER_BLOCK, 4);
    write_reg(sawlc_pkg::CFG_BLOCK_COUNT, 8);
    write_reg(sawlc_pkg::CFG_WAY_COUNT, 2);
    cfg_we <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      row_result = '{directed[i].hit, directed[i].wrote_back, directed[i].elapsed};
      send_request(directed[i].kind, directed[i].addr, directed[i].value,
                   directed[i].typed, row_result);
    end
    drain();

    // Phase 1: no idling, with one long receiver hold-off so the input backs up.
    // Size values that round to the same layout are rewritten between phases.
    write_reg(sawlc_pkg::CFG_HIT_COST, 0);
    write_reg(sawlc_pkg::CFG_MISS_COST, 1023);
    write_reg(sawlc_pkg::CFG_WORDS_PER_BLOCK, 7);
    cfg_we <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    random_requests(RANDOM_PER_PHASE);
    drain();

    // Phase 2: sender mostly idle; misses cost nothing, and once hits cost nothing too, each access stamps the total.
    write_reg(sawlc_pkg::CFG_HIT_COST, 255);
    write_reg(sawlc_pkg::CFG_MISS_COST, 0);
    write_reg(sawlc_pkg::CFG_BLOCK_COUNT, 15);
    cfg_we <= 1'b0;
    idle_pct = 88;
    stall_pct = 0;
    random_requests(RANDOM_PER_PHASE / 2);
    drain();
    write_reg(sawlc_pkg::CFG_HIT_COST, 0);
    write_reg(sawlc_pkg::CFG_WAY_COUNT, 3);
    cfg_we <= 1'b0;
    random_requests(RANDOM_PER_PHASE / 2);
    drain();

    // Phase 3: receiver mostly stalled.
    write_reg(sawlc_pkg::CFG_HIT_COST, 3);
    write_reg(sawlc_pkg::CFG_MISS_COST, 517);
    cfg_we <= 1'b0;
    idle_pct = 0;
    stall_pct = 88;
    random_requests(RANDOM_PER_PHASE);
    drain();

    // Phase 4: light idling on both sides.
    write_reg(sawlc_pkg::CFG_HIT_COST, 1);
    write_reg(sawlc_pkg::CFG_MISS_COST, 100);
    cfg_we <= 1'b0;
    idle_pct = 8;
    stall_pct = 8;
    random_requests(RANDOM_PER_PHASE);
    drain();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("set_assoc_writeback_lru_cache test passed");
    end else begin
      $display("set_assoc_writeback_lru_cache test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sawlc_pkg.sv
hw/rtl/sawlc_front.sv
hw/rtl/sawlc_queue.sv
hw/rtl/sawlc_back.sv
hw/rtl/set_assoc_writeback_lru_cache.sv
verif/set_assoc_writeback_lru_cache_test.sv
